/* design/alidr_pkg.sv */
// shared constants, types and element conversion functions for the array list block
package alidr_pkg;

  // list geometry
  localparam int CAPACITY   = 128;
  localparam int ELEM_WIDTH = 32;

  // fixed port widths
  localparam int CMD_W  = 2;
  localparam int POS_W  = 8;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 8;

  // derived widths
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DELETE  = 2'd1,
    CMD_REVERSE = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // datapath operation issued by the controller each cycle
  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_CHECK,
    DP_INS_RD,
    DP_INS_MV,
    DP_INS_WR,
    DP_DEL_RD,
    DP_DEL_CAP,
    DP_DEL_MV,
    DP_RD_RD,
    DP_RD_CAP,
    DP_RV_RD_LO,
    DP_RV_RD_HI,
    DP_RV_WR_HI,
    DP_RV_WR_LO,
    DP_FIN
  } dp_op_t;

  // datapath status toward the controller
  typedef struct packed {
    cmd_t cmd;
    logic ins_bad;
    logic full;
    logic pos_bad;
    logic append;
    logic del_tail;
    logic rv_short;
    logic ins_last;
    logic del_last;
    logic rv_more;
    logic out_free;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_RD,
    S_INS_MV,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_CAP,
    S_DEL_MV,
    S_RD_RD,
    S_RD_CAP,
    S_RV_RD_LO,
    S_RV_RD_HI,
    S_RV_WR_HI,
    S_RV_WR_LO,
    S_FIN
  } state_t;

  // input word to element width: sign-extend or truncate
  function automatic logic [ELEM_WIDTH-1:0] to_elem(input logic signed [DATA_W-1:0] w);
    logic signed [63:0] x;
    x = 64'(w);
    return x[ELEM_WIDTH-1:0];
  endfunction

  // stored element to output word: sign-extend or truncate
  function automatic logic [DATA_W-1:0] from_elem(input logic [ELEM_WIDTH-1:0] w);
    logic signed [ELEM_WIDTH-1:0] s;
    logic signed [63:0]           x;
    s = w;
    x = 64'(s);
    return x[DATA_W-1:0];
  endfunction

endpackage

/* design/array_list_insert_delete_reverse.sv */
// top level of the array list block: controller plus datapath
//
//   channel | ports                                      | direction
//   --------+--------------------------------------------+----------
//   input   | in_valid in_ready in_cmd in_position       | in
//           | in_value                                   |
//   result  | out_valid out_ready out_status             | out
//           | out_data_out out_list_length               |
//
// one command in flight; after load and decode a read runs RD_RD, RD_CAP; a
// delete DEL_RD, DEL_CAP, a DEL_MV per later entry; an end insert INS_WR;
// other inserts INS_RD, an INS_MV per entry from the position on, INS_WR; a
// reverse RV_RD_LO, then RV_RD_HI, RV_WR_HI, RV_WR_LO per pair; rejects and
// short-list reverses go to FIN. one store read and write per cycle set the
// move rate. reset clears the length count, state and result valid; the
// store is unknown until written, never read before. in_ready is high only
// between commands and out of reset; a finished result waits in the output
// register while the next beat is taken, and a second one holds the sequencer.
module array_list_insert_delete_reverse (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [alidr_pkg::CMD_W-1:0]         in_cmd,
  input  logic [alidr_pkg::POS_W-1:0]         in_position,
  input  logic signed [alidr_pkg::DATA_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [alidr_pkg::STAT_W-1:0]        out_status,
  output logic signed [alidr_pkg::DATA_W-1:0] out_data_out,
  output logic [alidr_pkg::LEN_W-1:0]         out_list_length
);
  import alidr_pkg::*;

  dp_op_t   op;
  dp_stat_t stat;

  // sequencer
  alidr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .op       (op)
  );

  // storage and result path
  alidr_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .op              (op),
    .stat            (stat),
    .in_cmd          (in_cmd),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_data_out    (out_data_out),
    .out_list_length (out_list_length)
  );

endmodule

/* design/alidr_ram.sv */
// generic single-write, single-read memory with registered read data
module alidr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/alidr_ctrl.sv */
// controller state machine sequencing list operations
module alidr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  alidr_pkg::dp_stat_t stat,
  output alidr_pkg::dp_op_t   op
);
  import alidr_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (stat.cmd)
          CMD_INSERT: begin
            if (stat.ins_bad || stat.full) state_nxt = S_FIN;
            else if (stat.append)          state_nxt = S_INS_WR;
            else                           state_nxt = S_INS_RD;
          end
          CMD_DELETE: begin
            state_nxt = stat.pos_bad ? S_FIN : S_DEL_RD;
          end
          CMD_READ: begin
            state_nxt = stat.pos_bad ? S_FIN : S_RD_RD;
          end
          CMD_REVERSE: begin
            state_nxt = stat.rv_short ? S_FIN : S_RV_RD_LO;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_INS_RD:   state_nxt = S_INS_MV;
      S_INS_MV: begin
        if (stat.ins_last) state_nxt = S_INS_WR;
      end
      S_INS_WR:   state_nxt = S_FIN;
      S_DEL_RD:   state_nxt = S_DEL_CAP;
      S_DEL_CAP:  state_nxt = stat.del_tail ? S_FIN : S_DEL_MV;
      S_DEL_MV: begin
        if (stat.del_last) state_nxt = S_FIN;
      end
      S_RD_RD:    state_nxt = S_RD_CAP;
      S_RD_CAP:   state_nxt = S_FIN;
      S_RV_RD_LO: state_nxt = S_RV_RD_HI;
      S_RV_RD_HI: state_nxt = S_RV_WR_HI;
      S_RV_WR_HI: state_nxt = S_RV_WR_LO;
      S_RV_WR_LO: state_nxt = stat.rv_more ? S_RV_RD_HI : S_FIN;
      S_FIN: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    op       = DP_NONE;
    unique case (state_r)
      S_IDLE: begin
        in_ready = rst_n;
        op       = in_valid ? DP_LOAD : DP_NONE;
      end
      S_DISPATCH: op = DP_CHECK;
      S_INS_RD:   op = DP_INS_RD;
      S_INS_MV:   op = DP_INS_MV;
      S_INS_WR:   op = DP_INS_WR;
      S_DEL_RD:   op = DP_DEL_RD;
      S_DEL_CAP:  op = DP_DEL_CAP;
      S_DEL_MV:   op = DP_DEL_MV;
      S_RD_RD:    op = DP_RD_RD;
      S_RD_CAP:   op = DP_RD_CAP;
      S_RV_RD_LO: op = DP_RV_RD_LO;
      S_RV_RD_HI: op = DP_RV_RD_HI;
      S_RV_WR_HI: op = DP_RV_WR_HI;
      S_RV_WR_LO: op = DP_RV_WR_LO;
      S_FIN:      op = DP_FIN;
      default:    op = DP_NONE;
    endcase
  end

endmodule

/* design/alidr_dp.sv */
// datapath: item registers, length count, entry store, move pointers and result register
module alidr_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  alidr_pkg::dp_op_t                   op,
  output alidr_pkg::dp_stat_t                 stat,
  input  logic [alidr_pkg::CMD_W-1:0]         in_cmd,
  input  logic [alidr_pkg::POS_W-1:0]         in_position,
  input  logic signed [alidr_pkg::DATA_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [alidr_pkg::STAT_W-1:0]        out_status,
  output logic signed [alidr_pkg::DATA_W-1:0] out_data_out,
  output logic [alidr_pkg::LEN_W-1:0]         out_list_length
);
  import alidr_pkg::*;

  // item registers
  cmd_t                  cmd_r;
  logic [POS_W-1:0]      pos_r;
  logic [ELEM_WIDTH-1:0] val_r;
  status_t               status_r;
  logic [DATA_W-1:0]     data_r;

  // list state and move pointers
  logic [CNT_W-1:0]      cnt_r;
  logic [ADDR_W-1:0]     ptr_r;
  logic [ADDR_W-1:0]     hi_r;
  logic [ELEM_WIDTH-1:0] tmp_r;

  // result register
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [DATA_W-1:0]     out_data_r;
  logic [LEN_W-1:0]      out_len_r;

  // store port
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [ELEM_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [ELEM_WIDTH-1:0] ram_rdata;

  // comparison values
  logic [CMP_W-1:0]      pos_c;
  logic [CMP_W-1:0]      cnt_c;
  logic [CMP_W-1:0]      ptr_c;
  logic [CMP_W-1:0]      hi_c;
  logic [ADDR_W-1:0]     pos_m1;
  logic [ADDR_W-1:0]     cnt_m1;
  logic                  out_free;

  assign pos_c    = CMP_W'(pos_r);
  assign cnt_c    = CMP_W'(cnt_r);
  assign ptr_c    = CMP_W'(ptr_r);
  assign hi_c     = CMP_W'(hi_r);
  assign pos_m1   = ADDR_W'(pos_c - CMP_W'(1));
  assign cnt_m1   = ADDR_W'(cnt_c - CMP_W'(1));
  assign out_free = !out_valid_r || out_ready;

  // status toward the controller
  always_comb begin
    stat.cmd      = cmd_r;
    stat.ins_bad  = (pos_c == '0) || (pos_c > cnt_c + CMP_W'(1));
    stat.full     = (cnt_c >= CMP_W'(CAPACITY));
    stat.pos_bad  = (pos_c == '0) || (pos_c > cnt_c);
    stat.append   = (pos_c == cnt_c + CMP_W'(1));
    stat.del_tail = (pos_c == cnt_c);
    stat.rv_short = (cnt_c <= CMP_W'(1));
    stat.ins_last = (ptr_r == pos_m1);
    stat.del_last = (ptr_c + CMP_W'(1) == cnt_c);
    stat.rv_more  = (ptr_c + CMP_W'(2) < hi_c);
    stat.out_free = out_free;
  end

  // store port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (op)
      DP_INS_RD: begin
        ram_re    = 1'b1;
        ram_raddr = cnt_m1;
      end
      DP_INS_MV: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(ptr_c + CMP_W'(1));
        ram_re    = (ptr_r != pos_m1);
        ram_raddr = ADDR_W'(ptr_c - CMP_W'(1));
      end
      DP_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_m1;
        ram_wdata = val_r;
      end
      DP_DEL_RD, DP_RD_RD: begin
        ram_re    = 1'b1;
        ram_raddr = pos_m1;
      end
      DP_DEL_CAP: begin
        ram_re    = (pos_c != cnt_c);
        ram_raddr = ADDR_W'(pos_c);
      end
      DP_DEL_MV: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(ptr_c - CMP_W'(1));
        ram_re    = (ptr_c + CMP_W'(1) != cnt_c);
        ram_raddr = ADDR_W'(ptr_c + CMP_W'(1));
      end
      DP_RV_RD_LO: begin
        ram_re    = 1'b1;
        ram_raddr = ptr_r;
      end
      DP_RV_RD_HI: begin
        ram_re    = 1'b1;
        ram_raddr = hi_r;
      end
      DP_RV_WR_HI: begin
        ram_we    = 1'b1;
        ram_waddr = hi_r;
        ram_wdata = tmp_r;
      end
      DP_RV_WR_LO: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        ram_re    = (ptr_c + CMP_W'(2) < hi_c);
        ram_raddr = ADDR_W'(ptr_c + CMP_W'(1));
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  alidr_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // length count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      unique case (op)
        DP_INS_WR: cnt_r <= cnt_r + CNT_W'(1);
        DP_DEL_CAP: begin
          if (pos_c == cnt_c) cnt_r <= cnt_r - CNT_W'(1);
        end
        DP_DEL_MV: begin
          if (ptr_c + CMP_W'(1) == cnt_c) cnt_r <= cnt_r - CNT_W'(1);
        end
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // item, pointer and scratch registers
  always_ff @(posedge clk) begin
    unique case (op)
      DP_LOAD: begin
        cmd_r    <= cmd_t'(in_cmd);
        pos_r    <= in_position;
        val_r    <= to_elem(in_value);
        status_r <= ST_OK;
        data_r   <= '0;
      end
      DP_CHECK: begin
        ptr_r <= '0;
        hi_r  <= cnt_m1;
        unique case (cmd_r)
          CMD_INSERT: begin
            if (stat.ins_bad)   status_r <= ST_RANGE;
            else if (stat.full) status_r <= ST_FULL;
          end
          CMD_DELETE, CMD_READ: begin
            if (stat.pos_bad) status_r <= ST_RANGE;
          end
          default: status_r <= ST_OK;
        endcase
      end
      DP_INS_RD: ptr_r <= cnt_m1;
      DP_INS_MV: begin
        if (ptr_r != pos_m1) ptr_r <= ADDR_W'(ptr_c - CMP_W'(1));
      end
      DP_DEL_CAP: begin
        data_r <= from_elem(ram_rdata);
        ptr_r  <= ADDR_W'(pos_c);
      end
      DP_DEL_MV: ptr_r <= ADDR_W'(ptr_c + CMP_W'(1));
      DP_RD_CAP: data_r <= from_elem(ram_rdata);
      DP_RV_RD_HI: tmp_r <= ram_rdata;
      DP_RV_WR_LO: begin
        ptr_r <= ADDR_W'(ptr_c + CMP_W'(1));
        hi_r  <= ADDR_W'(hi_c - CMP_W'(1));
      end
      default: begin
        ptr_r <= ptr_r;
      end
    endcase
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op == DP_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (op == DP_FIN && out_free) begin
      out_status_r <= status_r;
      out_data_r   <= data_r;
      out_len_r    <= LEN_W'(cnt_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_data_out    = out_data_r;
  assign out_list_length = out_len_r;

endmodule

/* sim/tb_array_list_insert_delete_reverse.sv */
// self-checking testbench for the array list block: directed and random commands against a list model
module tb_array_list_insert_delete_reverse;
  import alidr_pkg::*;

  localparam int ITEM_TARGET = 1950;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_WAIT  = 2 * CAPACITY + 16;
  localparam int HOLD_CYCLES = 500;
  localparam int HOLD_EVERY  = 700;

  typedef struct {
    cmd_t                     cmd;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
  } list_cmd_t;

  typedef struct {
    status_t                  status;
    logic signed [DATA_W-1:0] data;
    logic [LEN_W-1:0]         len;
  } list_result_t;

  logic                     clk;
  logic                     rst_n       = 1'b0;
  logic                     in_valid    = 1'b0;
  logic                     in_ready;
  logic [CMD_W-1:0]         in_cmd      = '0;
  logic [POS_W-1:0]         in_position = '0;
  logic signed [DATA_W-1:0] in_value    = '0;
  logic                     out_valid;
  logic                     out_ready   = 1'b0;
  logic [STAT_W-1:0]        out_status;
  logic signed [DATA_W-1:0] out_data_out;
  logic [LEN_W-1:0]         out_list_length;

  // list model state
  logic [ELEM_WIDTH-1:0] model_store [CAPACITY];
  int                    model_len = 0;

  list_cmd_t    pending_cmds [$];
  list_result_t expected_results [$];

  int gen_len       = 0;
  int error_count   = 0;
  int cycle_count   = 0;
  int results_seen  = 0;
  int tx_gap        = 0;
  int tx_quiet      = 0;
  int rx_stall      = 0;
  int rx_quiet      = 0;
  int rx_next       = 0;
  int hold_left     = 0;
  int next_hold_at  = 300;

  array_list_insert_delete_reverse DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_data_out    (out_data_out),
    .out_list_length (out_list_length)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_error(input string msg);
    $display("ERROR @%0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // apply one command to the list model and return the result it gives
  function automatic list_result_t apply_list_cmd(input cmd_t cmd, input logic [POS_W-1:0] pos,
                                                  input logic signed [DATA_W-1:0] value);
    list_result_t          r;
    int                    p;
    int                    lo;
    int                    hi;
    logic [ELEM_WIDTH-1:0] t;
    logic signed [ELEM_WIDTH-1:0] e;
    r.status = ST_OK;
    r.data   = '0;
    p        = pos;
    case (cmd)
      CMD_INSERT: begin
        if (p < 1 || p > model_len + 1) begin
          r.status = ST_RANGE;
        end else if (model_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int k = model_len; k >= p; k--) model_store[k] = model_store[k-1];
          model_store[p-1] = ELEM_WIDTH'(value);
          model_len++;
        end
      end
      CMD_DELETE: begin
        if (p < 1 || p > model_len) begin
          r.status = ST_RANGE;
        end else begin
          e      = model_store[p-1];
          r.data = DATA_W'(e);
          for (int k = p; k < model_len; k++) model_store[k-1] = model_store[k];
          model_len--;
        end
      end
      CMD_REVERSE: begin
        lo = 0;
        hi = model_len - 1;
        while (lo < hi) begin
          t               = model_store[lo];
          model_store[lo] = model_store[hi];
          model_store[hi] = t;
          lo++;
          hi--;
        end
      end
      default: begin
        if (p < 1 || p > model_len) begin
          r.status = ST_RANGE;
        end else begin
          e      = model_store[p-1];
          r.data = DATA_W'(e);
        end
      end
    endcase
    r.len = LEN_W'(model_len);
    return r;
  endfunction

  // idle length: mostly short, a few long, with runs of no idling
  function automatic int rand_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      quiet = $urandom_range(20, 60);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(DATA_W-1){1'b0}}};
      1:       return {1'b0, {(DATA_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // queue a command and track the list length it leaves
  task automatic push_cmd(input cmd_t cmd, input int pos, input logic signed [DATA_W-1:0] value);
    list_cmd_t c;
    c.cmd   = cmd;
    c.pos   = POS_W'(pos);
    c.value = value;
    pending_cmds.push_back(c);
    case (cmd)
      CMD_INSERT: if (pos >= 1 && pos <= gen_len + 1 && gen_len < CAPACITY) gen_len++;
      CMD_DELETE: if (pos >= 1 && pos <= gen_len) gen_len--;
      default: ;
    endcase
  endtask

  // position mostly in range, biased to the ends, sometimes out of range
  function automatic int pick_pos(input cmd_t cmd);
    int hi;
    int r;
    hi = (cmd == CMD_INSERT) ? gen_len + 1 : gen_len;
    r  = $urandom_range(0, 99);
    if (r < 8 || hi == 0) begin
      case ($urandom_range(0, 2))
        0:       return 0;
        1:       return hi + 1;
        default: return $urandom_range(hi + 1, 255);
      endcase
    end
    if (r < 20) return 1;
    if (r < 30) return hi;
    return $urandom_range(1, hi);
  endfunction

  // stimulus
  initial begin
    int   mode;
    int   run;
    int   r;
    cmd_t cmd;

    // directed: empty list, bad positions, extremes, short reverses, head and tail
    push_cmd(CMD_REVERSE, 0, '0);
    push_cmd(CMD_READ, 1, '0);
    push_cmd(CMD_DELETE, 1, '0);
    push_cmd(CMD_INSERT, 0, 32'sd5);
    push_cmd(CMD_INSERT, 2, 32'sd6);
    push_cmd(CMD_INSERT, 1, 32'sh7fffffff);
    push_cmd(CMD_REVERSE, 0, '1);
    push_cmd(CMD_INSERT, 1, 32'sh80000000);
    push_cmd(CMD_REVERSE, 255, '0);
    push_cmd(CMD_READ, 1, '0);
    push_cmd(CMD_READ, 2, '0);
    push_cmd(CMD_READ, 3, '0);
    push_cmd(CMD_INSERT, 3, '0);
    push_cmd(CMD_INSERT, 2, '1);
    push_cmd(CMD_READ, 0, '0);
    push_cmd(CMD_READ, 255, '0);
    push_cmd(CMD_DELETE, 255, '0);
    push_cmd(CMD_INSERT, 255, 32'sh55aa55aa);
    push_cmd(CMD_REVERSE, 0, '0);
    push_cmd(CMD_DELETE, 4, '0);
    push_cmd(CMD_DELETE, 1, '0);
    push_cmd(CMD_DELETE, 0, '0);
    push_cmd(CMD_DELETE, 1, '0);
    push_cmd(CMD_DELETE, 1, '0);
    push_cmd(CMD_REVERSE, 0, '0);

    // fill to capacity, then hit the full list
    while (gen_len < CAPACITY) push_cmd(CMD_INSERT, pick_pos(CMD_INSERT), rand_value());
    push_cmd(CMD_INSERT, 1, rand_value());
    push_cmd(CMD_INSERT, CAPACITY + 1, rand_value());
    push_cmd(CMD_INSERT, CAPACITY + 2, rand_value());
    push_cmd(CMD_READ, CAPACITY, '0);
    push_cmd(CMD_READ, CAPACITY + 1, '0);
    push_cmd(CMD_REVERSE, 0, '0);
    push_cmd(CMD_READ, 1, '0);
    push_cmd(CMD_DELETE, CAPACITY, '0);
    push_cmd(CMD_DELETE, 1, '0);

    // random phases: growing, shrinking, mixed and noise
    while (pending_cmds.size() < ITEM_TARGET) begin
      mode = $urandom_range(0, 9);
      run  = $urandom_range(20, 60);
      repeat (run) begin
        r = $urandom_range(0, 99);
        if (mode == 9) begin
          push_cmd(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 255), rand_value());
        end else begin
          if (mode < 3)
            cmd = cmd_t'((r < 75) ? CMD_INSERT : (r < 85) ? CMD_READ :
                         (r < 92) ? CMD_REVERSE : CMD_DELETE);
          else if (mode < 6)
            cmd = cmd_t'((r < 75) ? CMD_DELETE : (r < 85) ? CMD_READ :
                         (r < 92) ? CMD_REVERSE : CMD_INSERT);
          else
            cmd = cmd_t'($urandom_range(0, 3));
          push_cmd(cmd, pick_pos(cmd), rand_value());
        end
      end
    end
  end

  // reset and end of run
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_results.size() != 0)
      report_error($sformatf("%0d results never arrived", expected_results.size()));
    if (error_count == 0) begin
      $display("tb_array_list_insert_delete_reverse: done, clean");
    end else begin
      $display("tb_array_list_insert_delete_reverse: done, errors");
    end
    $finish;
  end

  // cycle count and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("TIMEOUT after %0d cycles", cycle_count);
    $display("tb_array_list_insert_delete_reverse: done, errors");
    $finish;
  end

  // driver: predict each accepted beat, then offer the next one after a gap
  always @(posedge clk) begin
    list_cmd_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(apply_list_cmd(cmd_t'(in_cmd), in_position, in_value));
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap   <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          item         = pending_cmds.pop_front();
          in_cmd      <= item.cmd;
          in_position <= item.pos;
          in_value    <= item.value;
          in_valid    <= 1'b1;
          tx_gap      <= rand_gap(tx_quiet);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off every few hundred results
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (results_seen >= next_hold_at) begin
      hold_left    <= HOLD_CYCLES;
      next_hold_at <= next_hold_at + HOLD_EVERY;
    end
  end

  // monitor: compare each result beat with the oldest prediction, stall at random
  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_stall  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          report_error($sformatf("unexpected result status=%0d data=%h len=%0d",
                                 out_status, out_data_out, out_list_length));
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            report_error($sformatf("status got %0d want %0d", out_status, want.status));
          if (out_data_out !== want.data)
            report_error($sformatf("data_out got %h want %h", out_data_out, want.data));
          if (out_list_length !== want.len)
            report_error($sformatf("list_length got %0d want %0d", out_list_length, want.len));
        end
      end
      if (rx_stall > 0) begin
        rx_stall  <= rx_stall - 1;
        out_ready <= 1'b0;
      end else begin
        rx_next    = rand_gap(rx_quiet);
        rx_stall  <= rx_next;
        out_ready <= (rx_next == 0) && (hold_left == 0);
      end
    end
  end

endmodule
